FILE: hw/rtl/half_weight_dot_product_unit_defines.svh
// Assertion helpers shared by the dot product unit
`ifndef HALF_WEIGHT_DOT_PRODUCT_UNIT_DEFINES_SVH
`define HALF_WEIGHT_DOT_PRODUCT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define HWDP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define HWDP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/hwdp_pkg.sv
package hwdp_pkg;

  localparam int LANES  = 8;
  localparam int LANE_W = $clog2(LANES);
  localparam int ADDR_W = 4;

  localparam logic [31:0] QNAN    = 32'h7FC0_0000;
  localparam logic [4:0]  H_EXP1  = 5'h1F;
  localparam logic [7:0]  F_EXP1  = 8'hFF;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_DEPTH = 2'd2;

  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic              last;
    logic [15:0]       row;
    logic [15:0]       col;
    logic              done;
  } hwdp_meta_t;

  // Finished lane sums handed to the reduction unit
  typedef struct packed {
    logic                   valid;
    logic [LANES-1:0][31:0] lanes;
    logic [15:0]            row;
    logic [15:0]            col;
    logic                   done;
  } hwdp_snap_t;

  function automatic logic [5:0] hwdp_lzc48(input logic [47:0] v);
    logic [5:0] lz;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) lz = 6'(47 - i);
    end
    return lz;
  endfunction

  function automatic logic [5:0] hwdp_lzc51(input logic [50:0] v);
    logic [5:0] lz;
    lz = 6'd0;
    for (int i = 0; i < 51; i++) begin
      if (v[i]) lz = 6'(50 - i);
    end
    return lz;
  endfunction

  // Widen a half to single precision exactly
  function automatic logic [31:0] hwdp_widen_half(input logic [15:0] h);
    logic       s;
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] pos;
    logic [9:0] fr;
    s   = h[15];
    e   = h[14:10];
    m   = h[9:0];
    pos = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) pos = 4'(i);
    end
    // Drop the leading one of a subnormal and left-align what lies below it
    fr = m << (4'd10 - pos);
    if (e == H_EXP1) begin
      return (m == 10'd0) ? {s, F_EXP1, 23'd0} : QNAN;
    end else if (e == 5'd0) begin
      if (m == 10'd0) return {s, 31'd0};
      return {s, 8'(8'd103 + {4'd0, pos}), fr, 13'd0};
    end
    return {s, 8'({3'd0, e} + 8'd112), m, 13'd0};
  endfunction

  // Round to nearest even; m holds the significand with its top bit at 47
  function automatic logic [31:0] hwdp_round_pack(input logic s,
                                                  input logic signed [11:0] be,
                                                  input logic [47:0] m);
    logic [47:0] sm;
    logic [47:0] mask;
    logic [11:0] shamt;
    logic [7:0]  ef;
    logic [22:0] mt;
    logic        g;
    logic        st;
    logic        rnd;
    logic [30:0] mag;
    sm    = m;
    mask  = 48'd0;
    shamt = 12'd0;
    st    = 1'b0;
    ef    = be[7:0];
    if (be >= 12'sd255) return {s, F_EXP1, 23'd0};
    if (be < 12'sd1) begin
      shamt = 12'(12'sd1 - be);
      ef    = 8'd0;
      if (shamt >= 12'd48) begin
        sm = 48'd0;
        st = |m;
      end else begin
        sm   = m >> shamt[5:0];
        mask = (48'd1 << shamt[5:0]) - 48'd1;
        st   = |(m & mask);
      end
    end
    mt  = sm[46:24];
    g   = sm[23];
    st  = st | (|sm[22:0]);
    rnd = g & (st | mt[0]);
    mag = {ef, mt} + 31'(rnd);
    return {s, mag};
  endfunction

  function automatic logic [31:0] hwdp_fmul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [47:0] p;
    logic [5:0]  lz;
    logic signed [11:0] be;
    s      = a[31] ^ b[31];
    nan_a  = (a[30:23] == F_EXP1) && (a[22:0] != 23'd0);
    nan_b  = (b[30:23] == F_EXP1) && (b[22:0] != 23'd0);
    inf_a  = (a[30:23] == F_EXP1) && (a[22:0] == 23'd0);
    inf_b  = (b[30:23] == F_EXP1) && (b[22:0] == 23'd0);
    zero_a = (a[30:0] == 31'd0);
    zero_b = (b[30:0] == 31'd0);
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
    p      = ma * mb;
    lz     = hwdp_lzc48(p);
    be     = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126 - $signed({6'd0, lz});
    if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) return QNAN;
    if (inf_a || inf_b) return {s, F_EXP1, 23'd0};
    if (zero_a || zero_b) return {s, 31'd0};
    return hwdp_round_pack(s, be, p << lz);
  endfunction

  function automatic logic [31:0] hwdp_fadd(input logic [31:0] a, input logic [31:0] b);
    logic        nan_a, nan_b, inf_a, inf_b;
    logic [31:0] x, y;
    logic [7:0]  ex, ey, d;
    logic [49:0] am, bf, bs;
    logic [50:0] r, rn;
    logic [5:0]  lz;
    logic        lost;
    logic signed [11:0] be;
    nan_a = (a[30:23] == F_EXP1) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == F_EXP1) && (b[22:0] != 23'd0);
    inf_a = (a[30:23] == F_EXP1) && (a[22:0] == 23'd0);
    inf_b = (b[30:23] == F_EXP1) && (b[22:0] == 23'd0);
    // Larger magnitude goes first
    if (a[30:0] < b[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    d  = ex - ey;
    am = {x[30:23] != 8'd0, x[22:0], 26'd0};
    bf = {y[30:23] != 8'd0, y[22:0], 26'd0};
    if (d >= 8'd50) begin
      bs = {49'd0, |bf};
    end else begin
      bs    = bf >> d[5:0];
      lost  = |(bf & ((50'd1 << d[5:0]) - 50'd1));
      bs[0] = bs[0] | lost;
    end
    r  = (x[31] == y[31]) ? ({1'b0, am} + {1'b0, bs}) : ({1'b0, am} - {1'b0, bs});
    lz = hwdp_lzc51(r);
    rn = r << lz;
    be = $signed({4'd0, ex}) + 12'sd1 - $signed({6'd0, lz});
    if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) return QNAN;
    if (inf_a) return a;
    if (inf_b) return b;
    if (r == 51'd0) return {a[31] & b[31], 31'd0};
    return hwdp_round_pack(x[31], be, {rn[50:4], rn[3] | (|rn[2:0])});
  endfunction

endpackage

FILE: hw/rtl/hwdp_if.sv
// Input item channel: one activation and one weight
interface hwdp_item_if;
  logic        valid;
  logic        ready;
  logic [31:0] activation;
  logic [15:0] weight;
  modport source (output valid, activation, weight, input ready);
  modport sink (input valid, activation, weight, output ready);
endinterface

// Result channel: one finished dot product
interface hwdp_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] dot_product;
  logic [15:0] row_index;
  logic [15:0] col_index;
  logic        matrix_done;
  modport source (output valid, dot_product, row_index, col_index, matrix_done, input ready);
  modport sink (input valid, dot_product, row_index, col_index, matrix_done, output ready);
endinterface

FILE: hw/rtl/hwdp_reduce.sv
`include "half_weight_dot_product_unit_defines.svh"

module hwdp_reduce (
  input  logic               clk,
  input  logic               rst,
  input  hwdp_pkg::hwdp_snap_t load,
  output logic               red_free,
  hwdp_result_if.source      result
);
  import hwdp_pkg::*;

  localparam logic [LANE_W-1:0] LAST_STEP = LANE_W'(LANES - 1);

  logic                   busy;
  logic [LANE_W-1:0]      step;
  logic [LANES-1:0][31:0] snap;
  logic [31:0]            racc;
  logic [15:0]            row;
  logic [15:0]            col;
  logic                   done;
  logic [31:0]            sum;
  logic [31:0]            canon;
  logic                   space;
  logic                   finish;

  // Shared adder walks the lanes in index order, from lane 0 upward
  assign sum    = hwdp_fadd(racc, snap[step]);
  assign canon  = ((sum[30:23] == F_EXP1) && (sum[22:0] != 23'd0)) ? QNAN : sum;
  assign space  = !result.valid || result.ready;
  assign finish = busy && (step == LAST_STEP) && space;
  assign red_free = !busy;

  // Sequence the reduction and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      step         <= '0;
      result.valid <= 1'b0;
    end else begin
      if (finish) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (load.valid) begin
        busy <= 1'b1;
        step <= LANE_W'(1);
      end else if (finish) begin
        busy <= 1'b0;
      end else if (busy && (step != LAST_STEP)) begin
        step <= step + LANE_W'(1);
      end
    end
  end

  // Payload: snapshot, running sum and the result fields
  always_ff @(posedge clk) begin
    if (load.valid) begin
      snap <= load.lanes;
      racc <= load.lanes[0];
      row  <= load.row;
      col  <= load.col;
      done <= load.done;
    end else if (busy && (step != LAST_STEP)) begin
      racc <= sum;
    end
    if (finish) begin
      result.dot_product <= canon;
      result.row_index   <= row;
      result.col_index   <= col;
      result.matrix_done <= done;
    end
  end

  `HWDP_ASSERT_NOW(a_load_idle, clk, rst, load.valid, !busy, "load while reducing")
  `HWDP_ASSERT_NEXT(a_load_start, clk, rst, load.valid, busy && (step == LANE_W'(1)), "bad start")
  `HWDP_ASSERT_NEXT(a_finish_out, clk, rst, finish, result.valid && !busy, "result lost")

endmodule

FILE: hw/rtl/half_weight_dot_product_unit.sv
// Streaming fp32 x fp16 dot product unit. Each item (single activation, half weight) is
// multiplied, rounded to nearest even, and added into one of eight lane sums; after depth
// items the lanes are summed in order and one result leaves, tagged with row and column,
// with matrix_done on the last element of the matrix. Items are accepted one per cycle
// while no finished item waits for the reduction unit: an input register, a multiply
// stage and a lane add. The final lane reduction runs on one shared adder alongside the
// next dot product; with depth below eight the input stalls until the reduction unit is
// free. The last item is handed to the reduction unit once it is free, and the result
// register is loaded when the reduction ends and the output is not stalled. Configuration
// writes take effect for the next item.
`include "half_weight_dot_product_unit_defines.svh"

module half_weight_dot_product_unit (
  input  logic                        clk,
  input  logic                        rst,
  hwdp_item_if.sink                   operand,
  hwdp_result_if.source               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hwdp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import hwdp_pkg::*;

  logic [15:0] rows;
  logic [15:0] cols;
  logic [15:0] depth;
  logic [15:0] ec;
  logic [15:0] row_cnt;
  logic [15:0] col_cnt;

  logic [16:0] klim, full, rlim, clim;
  logic [16:0] ec_inc, row_inc, col_inc;
  logic        lst_now, cdone, rdone, accept;
  hwdp_meta_t  meta_now;

  logic        v0, v1;
  logic [31:0] act0;
  logic [15:0] wt0;
  hwdp_meta_t  meta0, meta1;
  logic [31:0] prod1;
  logic        red_free, go1, adv1, adv0;

  logic [LANES-1:0][31:0] lanes;
  logic [31:0]            lane_sum;
  hwdp_snap_t             load;

  // Configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rows  <= 16'd1;
      cols  <= 16'd1;
      depth <= 16'd8;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_ROWS:  rows  <= pwdata[15:0];
        REG_COLS:  cols  <= pwdata[15:0];
        REG_DEPTH: depth <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROWS:  prdata = {16'd0, rows};
      REG_COLS:  prdata = {16'd0, cols};
      REG_DEPTH: prdata = {16'd0, depth};
      default:   prdata = 32'd0;
    endcase
  end

  // Position of the incoming item; a zero register means 65536
  assign klim    = (depth == 16'd0) ? 17'h10000 : {1'b0, depth};
  assign rlim    = (rows == 16'd0) ? 17'h10000 : {1'b0, rows};
  assign clim    = (cols == 16'd0) ? 17'h10000 : {1'b0, cols};
  assign full    = {klim[16:LANE_W], {LANE_W{1'b0}}};
  assign ec_inc  = {1'b0, ec} + 17'd1;
  assign row_inc = {1'b0, row_cnt} + 17'd1;
  assign col_inc = {1'b0, col_cnt} + 17'd1;
  assign lst_now = ec_inc >= klim;
  assign cdone   = col_inc >= clim;
  assign rdone   = row_inc >= rlim;

  always_comb begin
    meta_now.lane = ({1'b0, ec} < full) ? ec[LANE_W-1:0] : '0;
    meta_now.last = lst_now;
    meta_now.row  = row_cnt;
    meta_now.col  = col_cnt;
    meta_now.done = cdone && rdone;
  end

  // Pipeline flow: only a finishing item can wait, for the reduction unit
  assign go1           = v1 && (!meta1.last || red_free);
  assign adv1          = !v1 || go1;
  assign adv0          = !v0 || adv1;
  assign operand.ready = adv0;
  assign accept        = operand.valid && adv0;

  // Advance element, column and row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ec      <= 16'd0;
      row_cnt <= 16'd0;
      col_cnt <= 16'd0;
    end else if (accept) begin
      if (lst_now) begin
        ec <= 16'd0;
        if (cdone) begin
          col_cnt <= 16'd0;
          row_cnt <= rdone ? 16'd0 : row_inc[15:0];
        end else begin
          col_cnt <= col_inc[15:0];
        end
      end else begin
        ec <= ec_inc[15:0];
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (adv0) v0 <= operand.valid;
      if (adv1) v1 <= v0;
    end
  end

  // Input register, then widen and multiply
  always_ff @(posedge clk) begin
    if (accept) begin
      act0  <= operand.activation;
      wt0   <= operand.weight;
      meta0 <= meta_now;
    end
    if (adv1 && v0) begin
      prod1 <= hwdp_fmul(act0, hwdp_widen_half(wt0));
      meta1 <= meta0;
    end
  end

  // Lane accumulate; on the last element hand the lanes over and clear them
  assign lane_sum = hwdp_fadd(lanes[meta1.lane], prod1);

  always_comb begin
    load.valid = go1 && meta1.last;
    load.lanes = lanes;
    load.lanes[meta1.lane] = lane_sum;
    load.row   = meta1.row;
    load.col   = meta1.col;
    load.done  = meta1.done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lanes <= '0;
    end else if (go1) begin
      if (meta1.last) begin
        lanes <= '0;
      end else begin
        lanes[meta1.lane] <= lane_sum;
      end
    end
  end

  hwdp_reduce u_reduce (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .red_free (red_free),
    .result   (result)
  );

  `HWDP_ASSERT_NEXT(a_last_clears, clk, rst, accept && lst_now, ec == 16'd0, "count not cleared")
  `HWDP_ASSERT_NEXT(a_hold_wait, clk, rst, v1 && meta1.last && !red_free, v1, "item dropped")
  `HWDP_ASSERT_NOW(a_stall_full, clk, rst, !operand.ready, v0 && v1, "stall with a gap")

endmodule
